// ===== src/spfc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// spfc_pkg
// Types, status codes and the CRC-16/CCITT-FALSE byte update for the
// space packet frame checker.
// -----------------------------------------------------------------------------
package spfc_pkg;

	localparam int unsigned IDX_W    = 17;
	localparam int unsigned HDR_LEN  = 6;
	localparam int unsigned MIN_LEN  = 8;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_BAD_VER   = 3'd2,
		ST_LEN_ZERO  = 3'd3,
		ST_CRC_BAD   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_BODY   = 4'b0010,
		PH_DONE   = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// one byte of CRC, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== src/space_packet_frame_checker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// space_packet_frame_checker_unit
// Parses the six-byte primary header of each frame, forwards payload bytes,
// checks the trailing CRC-16/CCITT-FALSE and emits one verdict per frame.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per transaction,
//   with frame_end high on the last byte of the received frame.
//   Output channel (out_valid/out_ready) carries either a payload byte
//   (out_kind 0) or a frame verdict (out_kind 1) with the header fields and
//   a status. Payload bytes of a frame whose verdict is not ok are to be
//   dropped by the receiver.
//   Config channel (cfg_valid/cfg_ready) writes expected_version; it is
//   always ready. The user writes it only while the block is idle; the
//   block itself does not enforce this. Throughput is one byte per cycle
//   while the receiver does not stall. A byte is registered at acceptance,
//   processed once the output register is free, and its result, if any,
//   lands in the output register. The rate is set by the combinational CRC
//   byte update and header decode. When the receiver stalls, the output
//   register holds and the input stage keeps one byte; in_ready drops only
//   while both are full. Reset clears all frame state, sets the CRC to FFFF
//   and clears expected_version to zero. No clearing pass is needed.
// -----------------------------------------------------------------------------
module space_packet_frame_checker_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [7:0]       payload_byte,
	output logic [2:0]       status,
	output logic             packet_type,
	output logic [10:0]      apid,
	output logic [1:0]       sequence_flags,
	output logic [13:0]      sequence_count,
	output logic [15:0]      payload_length,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  expected_version
);
	import spfc_pkg::*;

	// input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	// frame state
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	logic [47:0]      hdr_q;
	logic [7:0]       crc_hi_q;
	phase_t           phase_q;
	status_t          pend_q;
	logic [2:0]       exp_ver_q;

	// output register
	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_byte_q;
	logic [2:0]       out_status_q;
	logic             out_type_q;
	logic [10:0]      out_apid_q;
	logic [1:0]       out_flags_q;
	logic [13:0]      out_count_q;
	logic [15:0]      out_len_q;

	logic             s1_go;
	logic             fire;

	// next-state and result
	logic [IDX_W-1:0] idx_inc;
	logic [IDX_W-1:0] idx_d;
	logic [15:0]      crc_d;
	logic [47:0]      hdr_d;
	logic [7:0]       crc_hi_d;
	phase_t           phase_d;
	status_t          pend_d;
	logic             res_d;
	logic             res_verdict;
	status_t          res_status;
	logic             clear_d;
	logic [15:0]      len_cur;
	logic [15:0]      len_new;
	logic [15:0]      crc_byte;
	logic [IDX_W-1:0] pay_pos;

	assign s1_go     = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || s1_go;
	assign fire      = valid_s1 && s1_go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ver_q <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			exp_ver_q <= expected_version;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= frame_end;
		end
	end

	assign crc_byte = crc_feed(crc_q, byte_s1);
	assign idx_inc  = (idx_q == {IDX_W{1'b1}}) ? idx_q : idx_q + 1'b1;
	assign len_cur  = hdr_q[15:0];
	assign pay_pos  = idx_q - IDX_W'(HDR_LEN - 1);

	always_comb begin
		hdr_d = hdr_q;
		if (phase_q == PH_HEADER) begin
			case (idx_q[2:0])
				3'd0:    hdr_d[47:40] = byte_s1;
				3'd1:    hdr_d[39:32] = byte_s1;
				3'd2:    hdr_d[31:24] = byte_s1;
				3'd3:    hdr_d[23:16] = byte_s1;
				3'd4:    hdr_d[15:8]  = byte_s1;
				3'd5:    hdr_d[7:0]   = byte_s1;
				default: hdr_d = hdr_q;
			endcase
		end
	end

	assign len_new = hdr_d[15:0];

	always_comb begin
		idx_d       = idx_inc;
		crc_d       = crc_q;
		crc_hi_d    = crc_hi_q;
		phase_d     = phase_q;
		pend_d      = pend_q;
		res_d       = 1'b0;
		res_verdict = 1'b0;
		res_status  = ST_OK;
		clear_d     = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				crc_d = crc_byte;
				if (idx_q == IDX_W'(HDR_LEN - 1)) begin
					if (hdr_d[47:45] != exp_ver_q) begin
						pend_d  = ST_BAD_VER;
						phase_d = PH_ERROR;
					end else if (len_new == 16'd0) begin
						pend_d  = ST_LEN_ZERO;
						phase_d = PH_ERROR;
					end else begin
						phase_d = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (pay_pos < {1'b0, len_cur}) begin
					crc_d = crc_byte;
					res_d = 1'b1;
				end else if (pay_pos == {1'b0, len_cur}) begin
					crc_hi_d = byte_s1;
				end else begin
					res_d       = 1'b1;
					res_verdict = 1'b1;
					res_status  = ({crc_hi_q, byte_s1} == crc_q) ? ST_OK : ST_CRC_BAD;
					phase_d     = PH_DONE;
				end
			end
			PH_ERROR: begin
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// end of frame: a verdict not yet given is given now
		if (last_s1) begin
			clear_d = 1'b1;
			if (!(phase_q == PH_DONE) && !(res_verdict)) begin
				res_d       = 1'b1;
				res_verdict = 1'b1;
				if (idx_inc < IDX_W'(MIN_LEN)) begin
					res_status = ST_TRUNCATED;
				end else if (pend_q != ST_OK) begin
					res_status = pend_q;
				end else begin
					res_status = ST_TRUNCATED;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			crc_q    <= CRC_INIT;
			hdr_q    <= '0;
			crc_hi_q <= 8'd0;
			phase_q  <= PH_HEADER;
			pend_q   <= ST_OK;
		end else if (fire) begin
			if (clear_d) begin
				idx_q    <= '0;
				crc_q    <= CRC_INIT;
				hdr_q    <= '0;
				crc_hi_q <= 8'd0;
				phase_q  <= PH_HEADER;
				pend_q   <= ST_OK;
			end else begin
				idx_q    <= idx_d;
				crc_q    <= crc_d;
				hdr_q    <= hdr_d;
				crc_hi_q <= crc_hi_d;
				phase_q  <= phase_d;
				pend_q   <= pend_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= valid_s1 && res_d;
		end
	end

	// load the result register; payload results carry zero header fields
	always_ff @(posedge clk) begin
		if (fire && res_d) begin
			if (res_verdict) begin
				out_kind_q   <= KIND_VERDICT;
				out_byte_q   <= 8'd0;
				out_status_q <= res_status;
				out_type_q   <= hdr_d[44];
				out_apid_q   <= hdr_d[42:32];
				out_flags_q  <= hdr_d[31:30];
				out_count_q  <= hdr_d[29:16];
				out_len_q    <= (len_new == 16'd0) ? 16'd0 : len_new - 16'd1;
			end else begin
				out_kind_q   <= KIND_PAYLOAD;
				out_byte_q   <= byte_s1;
				out_status_q <= ST_OK;
				out_type_q   <= 1'b0;
				out_apid_q   <= 11'd0;
				out_flags_q  <= 2'd0;
				out_count_q  <= 14'd0;
				out_len_q    <= 16'd0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign payload_byte   = out_byte_q;
	assign status         = out_status_q;
	assign packet_type    = out_type_q;
	assign apid           = out_apid_q;
	assign sequence_flags = out_flags_q;
	assign sequence_count = out_count_q;
	assign payload_length = out_len_q;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last_s1) |=> (idx_q == '0 && phase_q == PH_HEADER && crc_q == CRC_INIT))
		else $error("frame state not cleared after frame end");

	a_body_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) |-> (idx_q >= IDX_W'(HDR_LEN)))
		else $error("body phase entered before header complete");

	a_pending_matches_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) == (pend_q != ST_OK))
		else $error("pending error out of step with error phase");

	a_payload_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q == KIND_PAYLOAD) |->
		(out_status_q == ST_OK && out_len_q == 16'd0 && out_apid_q == 11'd0))
		else $error("payload result carries verdict fields");

endmodule
`default_nettype wire
